>>> rtl/tdcc_pkg.sv
`timescale 1ns / 1ps

package tdcc_pkg;

  localparam int SECTOR_W = 54;
  localparam int LEN_W    = 32;
  localparam int CNT_W    = 24;
  localparam int WIDE_W   = 64;
  localparam int STRIPE_W = 17;
  localparam int SECB_W   = 17;
  localparam int DRV_W    = 8;
  localparam int CAP_W    = 32;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  localparam logic [STRIPE_W-1:0] STRIPE_RST = 17'd8;
  localparam logic [SECB_W-1:0]   SECB_RST   = 17'd512;
  localparam logic [DRV_W-1:0]    DRV_RST    = 8'd1;
  localparam logic [CAP_W-1:0]    CAP_RST    = 32'd65535;

  typedef enum logic [1:0] {
    REG_STRIPE_LBAS  = 2'd0,
    REG_SECTOR_BYTES = 2'd1,
    REG_DRIVE_COUNT  = 2'd2,
    REG_MAX_DISCARD  = 2'd3
  } reg_idx_t;

  // divisors already forced non-zero
  typedef struct packed {
    logic [STRIPE_W-1:0] stripe;
    logic [SECB_W-1:0]   secb;
    logic [DRV_W-1:0]    drives;
    logic [CAP_W-1:0]    max_lbas;
  } cfg_t;

  typedef struct packed {
    logic disc;
  } pa_t;

  typedef struct packed {
    logic              disc;
    logic [WIDE_W-1:0] lbas;
  } pb_t;

  typedef struct packed {
    logic             disc;
    logic             short_range;
    logic [1:0]       frag;
    logic             lbas_nz;
    logic [CAP_W-1:0] cap;
  } pc_t;

  typedef struct packed {
    pc_t              c;
    logic [DRV_W-1:0] stripes_lo;
  } pd_t;

  typedef struct packed {
    logic             disc;
    logic             short_range;
    logic [1:0]       frag;
    logic             lbas_nz;
    logic             q_zero;
    logic [DRV_W-1:0] stripes_lo;
    logic [DRV_W-1:0] rem_lo;
    logic             over;
    logic             cap_zero;
  } pe_t;

endpackage

>>> rtl/tdcc_div.sv
`timescale 1ns / 1ps

module tdcc_div #(
  parameter int N = 64,
  parameter int M = 17,
  parameter int P = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] in_dividend,
  input  logic [M-1:0] in_divisor,
  input  logic [P-1:0] in_payload,
  output logic         out_valid,
  output logic [N-1:0] out_quot,
  output logic [M-1:0] out_rem,
  output logic [P-1:0] out_payload
);

  // one quotient bit per stage, restoring
  logic         v   [N];
  logic [M-1:0] rem [N];
  logic [N-1:0] dq  [N];
  logic [M-1:0] dv  [N];
  logic [P-1:0] pl  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic         pv;
    logic [M-1:0] prem;
    logic [N-1:0] pdq;
    logic [M-1:0] pdv;
    logic [P-1:0] ppl;
    logic [M:0]   trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign pv   = in_valid;
      assign prem = '0;
      assign pdq  = in_dividend;
      assign pdv  = in_divisor;
      assign ppl  = in_payload;
    end else begin : g_next
      assign pv   = v[k-1];
      assign prem = rem[k-1];
      assign pdq  = dq[k-1];
      assign pdv  = dv[k-1];
      assign ppl  = pl[k-1];
    end

    assign trial = {prem, pdq[N-1]};
    assign ge    = trial >= {1'b0, pdv};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= pv;
      end
      if (en) begin
        rem[k] <= ge ? M'(trial - {1'b0, pdv}) : trial[M-1:0];
        dq[k]  <= {pdq[N-2:0], ge};
        dv[k]  <= pdv;
        pl[k]  <= ppl;
      end
    end
  end

  assign out_valid   = v[N-1];
  assign out_quot    = dq[N-1];
  assign out_rem     = rem[N-1];
  assign out_payload = pl[N-1];

endmodule

>>> rtl/tdcc_regs.sv
`timescale 1ns / 1ps

module tdcc_regs
  import tdcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [STRIPE_W-1:0] stripe_lbas;
  logic [SECB_W-1:0]   sector_bytes;
  logic [DRV_W-1:0]    drive_count;
  logic [CAP_W-1:0]    max_discard_lbas;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      stripe_lbas      <= STRIPE_RST;
      sector_bytes     <= SECB_RST;
      drive_count      <= DRV_RST;
      max_discard_lbas <= CAP_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_STRIPE_LBAS:  stripe_lbas      <= pwdata[STRIPE_W-1:0];
        REG_SECTOR_BYTES: sector_bytes     <= pwdata[SECB_W-1:0];
        REG_DRIVE_COUNT:  drive_count      <= pwdata[DRV_W-1:0];
        REG_MAX_DISCARD:  max_discard_lbas <= pwdata[CAP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STRIPE_LBAS:  prdata = DATA_W'(stripe_lbas);
      REG_SECTOR_BYTES: prdata = DATA_W'(sector_bytes);
      REG_DRIVE_COUNT:  prdata = DATA_W'(drive_count);
      REG_MAX_DISCARD:  prdata = DATA_W'(max_discard_lbas);
    endcase
  end

  // a zero divisor behaves as one
  assign cfg.stripe   = (stripe_lbas == '0) ? STRIPE_W'(1) : stripe_lbas;
  assign cfg.secb     = (sector_bytes == '0) ? SECB_W'(1) : sector_bytes;
  assign cfg.drives   = (drive_count == '0) ? DRV_W'(1) : drive_count;
  assign cfg.max_lbas = max_discard_lbas;

endmodule

>>> rtl/trim_discard_command_count.sv
`timescale 1ns / 1ps
// The result beat passes through five 64-step divider pipelines (one quotient bit
// per stage) in series.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset (rst, synchronous): clears all valid bits and loads register defaults.

module trim_discard_command_count
  import tdcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // start_sector[53:0], byte_length[85:54], zeros
  input  logic                  s_tuser,  // is_discard
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // command_count[23:0]
  output logic                  m_tuser,  // cap_error
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  cfg_t cfg;
  logic en;

  tdcc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: byte range
  logic [LEN_W-1:0]  len_nz;
  logic [WIDE_W-1:0] first_in;
  logic              s0_v, s0_disc;
  logic [WIDE_W-1:0] s0_first, s0_last;

  assign len_nz   = (s_tdata[85:54] == '0) ? LEN_W'(1) : s_tdata[85:54];
  assign first_in = {1'b0, s_tdata[SECTOR_W-1:0], 9'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= s_tvalid;
    end
    if (en) begin
      s0_disc  <= s_tuser;
      s0_first <= first_in;
      s0_last  <= first_in + WIDE_W'(len_nz) - WIDE_W'(1);
    end
  end

  // byte offsets to LBAs
  logic              a1_v, a2_v;
  logic [WIDE_W-1:0] a1_q, a2_q;
  pa_t               a_pl;

  tdcc_div #(.N(WIDE_W), .M(SECB_W), .P($bits(pa_t))) u_div_first (
    .clk, .rst, .en, .in_valid(s0_v), .in_dividend(s0_first), .in_divisor(cfg.secb),
    .in_payload(s0_disc), .out_valid(a1_v), .out_quot(a1_q), .out_rem(),
    .out_payload(a_pl)
  );

  tdcc_div #(.N(WIDE_W), .M(SECB_W), .P($bits(pa_t))) u_div_last (
    .clk, .rst, .en, .in_valid(s0_v), .in_dividend(s0_last), .in_divisor(cfg.secb),
    .in_payload(s0_disc), .out_valid(a2_v), .out_quot(a2_q), .out_rem(),
    .out_payload()
  );

  logic              b_v;
  logic [WIDE_W-1:0] b_first, b_lastp1;
  pb_t               b_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a1_v;
    end
    if (en) begin
      b_first     <= a1_q;
      b_lastp1    <= a2_q + WIDE_W'(1);
      b_pl.disc   <= a_pl.disc;
      b_pl.lbas   <= a2_q - a1_q + WIDE_W'(1);
    end
  end

  // stripe offsets and command cap in stripes
  logic                b1_v, b3_v;
  logic [STRIPE_W-1:0] b1_rem, b2_rem;
  logic [WIDE_W-1:0]   b3_q;
  pb_t                 bo_pl;

  tdcc_div #(.N(WIDE_W), .M(STRIPE_W), .P($bits(pb_t))) u_div_head (
    .clk, .rst, .en, .in_valid(b_v), .in_dividend(b_first), .in_divisor(cfg.stripe),
    .in_payload(b_pl), .out_valid(b1_v), .out_quot(), .out_rem(b1_rem),
    .out_payload(bo_pl)
  );

  tdcc_div #(.N(WIDE_W), .M(STRIPE_W), .P(1)) u_div_tail (
    .clk, .rst, .en, .in_valid(b_v), .in_dividend(b_lastp1), .in_divisor(cfg.stripe),
    .in_payload(1'b0), .out_valid(), .out_quot(), .out_rem(b2_rem), .out_payload()
  );

  tdcc_div #(.N(WIDE_W), .M(STRIPE_W), .P(1)) u_div_cap (
    .clk, .rst, .en, .in_valid(b_v), .in_dividend(WIDE_W'(cfg.max_lbas)),
    .in_divisor(cfg.stripe), .in_payload(1'b0), .out_valid(b3_v), .out_quot(b3_q),
    .out_rem(), .out_payload()
  );

  // fragments, three short stages
  logic                c1_v, c1_disc;
  logic [WIDE_W-1:0]   c1_lbas;
  logic [STRIPE_W-1:0] c1_head, c1_tail;
  logic [CAP_W-1:0]    c1_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
    end else if (en) begin
      c1_v <= b1_v;
    end
    if (en) begin
      c1_disc <= bo_pl.disc;
      c1_lbas <= bo_pl.lbas;
      c1_head <= (b1_rem != '0) ? cfg.stripe - b1_rem : '0;
      c1_tail <= b2_rem;
      c1_cap  <= b3_q[CAP_W-1:0];
    end
  end

  logic                c2_v, c2_disc, c2_short, c2_frag;
  logic [WIDE_W-1:0]   c2_lbas;
  logic [STRIPE_W-1:0] c2_tail;
  logic [CAP_W-1:0]    c2_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v <= 1'b0;
    end else if (en) begin
      c2_v <= c1_v;
    end
    if (en) begin
      c2_disc  <= c1_disc;
      c2_short <= WIDE_W'(c1_head) >= c1_lbas;
      c2_frag  <= c1_head != '0;
      c2_lbas  <= c1_lbas - WIDE_W'(c1_head);
      c2_tail  <= c1_tail;
      c2_cap   <= c1_cap;
    end
  end

  logic              c3_v;
  logic [WIDE_W-1:0] c3_lbas;
  pc_t               c3_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_v <= 1'b0;
    end else if (en) begin
      c3_v <= c2_v;
    end
    if (en) begin
      c3_pl.disc        <= c2_disc;
      c3_pl.short_range <= c2_short;
      c3_pl.cap         <= c2_cap;
      if (c2_tail != '0) begin
        c3_lbas       <= (WIDE_W'(c2_tail) <= c2_lbas) ? c2_lbas - WIDE_W'(c2_tail) : '0;
        c3_pl.lbas_nz <= WIDE_W'(c2_tail) < c2_lbas;
        c3_pl.frag    <= {1'b0, c2_frag} + 2'd1;
      end else begin
        c3_lbas       <= c2_lbas;
        c3_pl.lbas_nz <= c2_lbas != '0;
        c3_pl.frag    <= {1'b0, c2_frag};
      end
    end
  end

  // whole stripes, then stripes per drive
  logic              cs_v;
  logic [WIDE_W-1:0] cs_q;
  pc_t               cs_pl;
  pd_t               d_in;

  tdcc_div #(.N(WIDE_W), .M(STRIPE_W), .P($bits(pc_t))) u_div_stripes (
    .clk, .rst, .en, .in_valid(c3_v), .in_dividend(c3_lbas), .in_divisor(cfg.stripe),
    .in_payload(c3_pl), .out_valid(cs_v), .out_quot(cs_q), .out_rem(),
    .out_payload(cs_pl)
  );

  assign d_in.c          = cs_pl;
  assign d_in.stripes_lo = cs_q[DRV_W-1:0];

  logic              d_v;
  logic [WIDE_W-1:0] d_q;
  logic [DRV_W-1:0]  d_rem;
  pd_t               d_pl;

  tdcc_div #(.N(WIDE_W), .M(DRV_W), .P($bits(pd_t))) u_div_drives (
    .clk, .rst, .en, .in_valid(cs_v), .in_dividend(cs_q), .in_divisor(cfg.drives),
    .in_payload(d_in), .out_valid(d_v), .out_quot(d_q), .out_rem(d_rem),
    .out_payload(d_pl)
  );

  // per-drive stripes against the cap
  logic              e_v;
  logic [WIDE_W-1:0] e_pd;
  logic [CAP_W-1:0]  e_cap;
  pe_t               e_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= d_v;
    end
    if (en) begin
      e_pd             <= d_q + WIDE_W'(d_rem != '0);
      e_cap            <= d_pl.c.cap;
      e_pl.disc        <= d_pl.c.disc;
      e_pl.short_range <= d_pl.c.short_range;
      e_pl.frag        <= d_pl.c.frag;
      e_pl.lbas_nz     <= d_pl.c.lbas_nz;
      e_pl.q_zero      <= d_q == '0;
      e_pl.stripes_lo  <= d_pl.stripes_lo;
      e_pl.rem_lo      <= d_rem;
      e_pl.over        <= (d_q > WIDE_W'(d_pl.c.cap)) ||
                          ((d_q == WIDE_W'(d_pl.c.cap)) && (d_rem != '0));
      e_pl.cap_zero    <= d_pl.c.cap == '0;
    end
  end

  logic              eq_v;
  logic [WIDE_W-1:0] eq_q;
  pe_t               eq_pl;

  tdcc_div #(.N(WIDE_W), .M(CAP_W), .P($bits(pe_t))) u_div_split (
    .clk, .rst, .en, .in_valid(e_v), .in_dividend(e_pd), .in_divisor(e_cap),
    .in_payload(e_pl), .out_valid(eq_v), .out_quot(eq_q), .out_rem(),
    .out_payload(eq_pl)
  );

  // scale by drive count, saturate wide quotients
  logic                  f_v, f_sat;
  logic [CNT_W+DRV_W-1:0] f_prod;
  pe_t                   f_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= eq_v;
    end
    if (en) begin
      f_sat  <= eq_q[WIDE_W-1:CNT_W] != '0;
      f_prod <= eq_q[CNT_W-1:0] * cfg.drives;
      f_pl   <= eq_pl;
    end
  end

  // final count
  logic [CNT_W+DRV_W:0] split_sum;
  logic [CNT_W-1:0]     count_next;
  logic                 err_next;

  assign split_sum = (CNT_W+DRV_W+1)'(f_prod) + (CNT_W+DRV_W+1)'(f_pl.rem_lo)
                   + (CNT_W+DRV_W+1)'(f_pl.frag);

  always_comb begin
    err_next = 1'b0;
    priority if (!f_pl.disc) begin
      count_next = '0;
    end else if (f_pl.short_range) begin
      count_next = CNT_W'(1);
    end else if (!f_pl.lbas_nz) begin
      count_next = CNT_W'(f_pl.frag);
    end else if (f_pl.q_zero) begin
      count_next = CNT_W'(f_pl.frag) + CNT_W'(f_pl.stripes_lo);
    end else if (!f_pl.over) begin
      count_next = CNT_W'(f_pl.frag) + CNT_W'(cfg.drives);
    end else if (f_pl.cap_zero) begin
      count_next = '0;
      err_next   = 1'b1;
    end else if (f_sat || (split_sum > (CNT_W+DRV_W+1)'(CNT_SAT))) begin
      count_next = CNT_SAT;
    end else begin
      count_next = split_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f_v;
    end
    if (en) begin
      m_tdata <= count_next;
      m_tuser <= err_next;
    end
  end

  a_err_count_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("cap error with non-zero count");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (a1_v == a2_v) && (b1_v == b3_v))
    else $error("divider lanes out of step");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !f_v)
    else $error("pipeline not empty after reset");

endmodule

>>> tb/sv/tdcc_checker.sv
`timescale 1ns / 1ps

module tdcc_checker
  import tdcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // start_sector[53:0], byte_length[85:54], zeros
  input  logic                  s_tuser,  // is_discard
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,  // command_count[23:0]
  input  logic                  m_tuser,  // cap_error
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             err;
  } cmd_count_t;

  logic [STRIPE_W-1:0] stripe_q;
  logic [SECB_W-1:0]   secb_q;
  logic [DRV_W-1:0]    drives_q;
  logic [CAP_W-1:0]    cap_q;
  cmd_count_t          counts_due[$];

  assign outstanding = counts_due.size();

  function automatic cmd_count_t count_commands(logic disc, logic [SECTOR_W-1:0] sect,
                                                logic [LEN_W-1:0] blen);
    logic [63:0] stripe, sec, drv, len, first, last, lbas, head, tail;
    logic [63:0] stripes, per_drv, cap, n;
    cmd_count_t r;
    stripe = (stripe_q == 0) ? 64'd1 : 64'(stripe_q);
    sec    = (secb_q == 0) ? 64'd1 : 64'(secb_q);
    drv    = (drives_q == 0) ? 64'd1 : 64'(drives_q);
    len    = (blen == 0) ? 64'd1 : 64'(blen);
    n      = 0;
    r.err  = 1'b0;
    if (disc) begin
      first = 64'(sect) << 9;
      last  = (first + len - 1) / sec;
      first = first / sec;
      lbas  = 1 + last - first;
      head  = first % stripe;
      if (head != 0) head = stripe - head;
      tail  = (last + 1) % stripe;
      if (head >= lbas) begin
        n = 1;
      end else begin
        if (head != 0) begin
          lbas = lbas - head;
          n++;
        end
        if (tail != 0) begin
          lbas = (tail <= lbas) ? lbas - tail : 64'd0;
          n++;
        end
        if (lbas != 0) begin
          stripes = lbas / stripe;
          if (stripes / drv == 0) begin
            n += stripes;
          end else begin
            per_drv = stripes / drv + ((stripes % drv != 0) ? 64'd1 : 64'd0);
            cap     = 64'(cap_q) / stripe;
            if (per_drv > cap) begin
              if (cap == 0) begin
                n     = 0;
                r.err = 1'b1;
              end else begin
                n += (per_drv / cap) * drv + stripes % drv;
              end
            end else begin
              n += drv;
            end
          end
        end
      end
    end
    r.cnt = (n > 64'hFFFFFF) ? 24'hFFFFFF : n[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_count_t want;
    if (rst) begin
      stripe_q   <= STRIPE_RST;
      secb_q     <= SECB_RST;
      drives_q   <= DRV_RST;
      cap_q      <= CAP_RST;
      mismatches <= 0;
      counts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_STRIPE_LBAS:  stripe_q <= pwdata[STRIPE_W-1:0];
          REG_SECTOR_BYTES: secb_q   <= pwdata[SECB_W-1:0];
          REG_DRIVE_COUNT:  drives_q <= pwdata[DRV_W-1:0];
          REG_MAX_DISCARD:  cap_q    <= pwdata[CAP_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        counts_due.push_back(count_commands(s_tuser, s_tdata[SECTOR_W-1:0],
                                            s_tdata[SECTOR_W +: LEN_W]));
      if (m_tvalid && m_tready) begin
        if (counts_due.size() == 0) begin
          $display("%0t: unexpected beat, actual count %0d err %0b",
                   $time, m_tdata, m_tuser);
          mismatches <= mismatches + 1;
        end else begin
          want = counts_due.pop_front();
          if (want.cnt !== m_tdata || want.err !== m_tuser) begin
            $display("%0t: expected count %0d err %0b, actual count %0d err %0b",
                     $time, want.cnt, want.err, m_tdata, m_tuser);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb_trim_discard_command_count.sv
`timescale 1ns / 1ps

module tb_trim_discard_command_count;
  import tdcc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready, s_tuser;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid, m_tready, m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata, prdata;
  int                    mismatches, outstanding;
  int                    idle_cycles;
  int                    hold_left;
  bit                    no_gaps;

  trim_discard_command_count dut (.*);
  tdcc_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || no_gaps) begin
      m_tready  <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 15);
      m_tready  <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_array(logic [DATA_W-1:0] stripe, logic [DATA_W-1:0] secb,
                           logic [DATA_W-1:0] drv, logic [DATA_W-1:0] cap);
    // drop the last beat and let the pipeline drain before touching registers
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    write_reg(REG_STRIPE_LBAS, stripe);
    write_reg(REG_SECTOR_BYTES, secb);
    write_reg(REG_DRIVE_COUNT, drv);
    write_reg(REG_MAX_DISCARD, cap);
  endtask

  task automatic send(logic disc, logic [SECTOR_W-1:0] sect, logic [LEN_W-1:0] blen);
    int gap;
    if (!no_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= disc;
    s_tdata  <= {2'b00, blen, sect};
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly discards over a spread of alignments and sizes
  task automatic send_random();
    logic [SECTOR_W-1:0] sect;
    logic [LEN_W-1:0]    blen;
    case ($urandom_range(0, 3))
      0: sect = SECTOR_W'({$urandom(), $urandom()});
      1: sect = SECTOR_W'($urandom_range(0, 4095));
      default: sect = SECTOR_W'($urandom() >> $urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 4))
      0: blen = $urandom();
      1: blen = $urandom_range(0, 600);
      2: blen = ($urandom() >> $urandom_range(0, 31)) << 9;
      default: blen = $urandom() >> $urandom_range(0, 31);
    endcase
    send($urandom_range(0, 9) != 0, sect, blen);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: stripe 8, 512-byte sectors, one drive
    send(1'b0, 54'd100, 32'd4096);
    send(1'b1, 54'd0, 32'd1);
    send(1'b1, 54'd0, 32'd0);
    send(1'b1, 54'd3, 32'd1024);
    send(1'b1, 54'd0, 32'd4096);
    send(1'b1, 54'd5, 32'd8192);
    send(1'b1, {SECTOR_W{1'b1}}, {LEN_W{1'b1}});
    send(1'b1, 54'd0, {LEN_W{1'b1}});
    // overflow past the cap, then a cap below one stripe
    set_array(32'd8, 32'd512, 32'd4, 32'd16);
    send(1'b1, 54'd0, 32'd1 << 20);
    send(1'b1, 54'd1, 32'd1 << 20);
    set_array(32'd8, 32'd512, 32'd2, 32'd7);
    send(1'b1, 54'd0, 32'd1 << 16);
    send(1'b1, 54'd0, 32'd4096);
    send(1'b1, 54'd2, 32'd2048);
    // extremes of drive count and cap, then all registers zero (zero divisors act as one)
    set_array(32'd1, 32'd512, 32'd1, 32'd1);
    send(1'b1, 54'd7, {LEN_W{1'b1}});
    send(1'b1, {SECTOR_W{1'b1}}, 32'd512);
    set_array(32'd65536, 32'd65536, 32'd255, 32'hFFFF_FFFF);
    send(1'b1, 54'd0, {LEN_W{1'b1}});
    send(1'b1, {SECTOR_W{1'b1}}, {LEN_W{1'b1}});
    set_array(32'd0, 32'd0, 32'd0, 32'd0);
    send(1'b1, 54'd9, 32'd5000);
    send(1'b1, 54'd0, 32'd300);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_array(32'd8, 32'd512, 32'd1, 32'd65535);
        1: set_array(32'd65536, 32'd65536, 32'd255, 32'hFFFF_FFFF);
        2: set_array(32'd1, 32'd512, 32'd1, 32'd1);
        default: set_array($urandom_range(1, 64), 32'd512 << $urandom_range(0, 7),
                           ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 8),
                           ($urandom_range(0, 2) == 0) ? $urandom()
                                                       : $urandom_range(0, 600));
      endcase
      if (ph == 7) no_gaps = 1'b1;
      repeat (230) send_random();
    end
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> trim_discard_command_count.f
rtl/tdcc_pkg.sv
rtl/tdcc_div.sv
rtl/tdcc_regs.sv
rtl/trim_discard_command_count.sv
tb/sv/tdcc_checker.sv
tb/sv/tb_trim_discard_command_count.sv
